/* rtl/pareto_filter_table_defines.svh */
// Assertion macros used by the filter table checker.
`ifndef PARETO_FILTER_TABLE_DEFINES_SVH
`define PARETO_FILTER_TABLE_DEFINES_SVH

// Same-cycle implication.
`define PFT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define PFT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/pft_pkg.sv */
// Types, constants and codes of the Pareto filter table.
package pft_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_CNT_W   = 7;
    localparam int VAL_W       = 32;
    localparam int MARGIN_W    = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int ENTRY_W     = 2 * VAL_W;

    localparam logic [MODE_W-1:0] MODE_CHECK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INIT    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 1'b1;

    localparam logic [MARGIN_W-1:0] BETA_RESET  = 16'd64881;
    localparam logic [MARGIN_W-1:0] GAMMA_RESET = 16'd1;

    localparam logic [OUT_CNT_W-1:0] FULL_CNT = OUT_CNT_W'(TABLE_DEPTH);

    typedef struct packed {
        logic [VAL_W-1:0] viol;
        logic [VAL_W-1:0] obj;
    } t_entry;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [VAL_W-1:0]    t;
        logic [VAL_W-1:0]    f;
        logic [VAL_W-1:0]    gt;
        logic [MARGIN_W-1:0] beta;
    } t_cmp_ctl;

    typedef struct packed {
        logic   valid;
        t_entry entry;
        logic   kill;
        logic   pass;
    } t_cmp_res;

endpackage

/* rtl/pft_if.sv */
// Handshake channels of the Pareto filter table: items, results, configuration.
interface pft_in_if;
    logic                            valid;
    logic                            ready;
    logic [pft_pkg::MODE_W-1:0]      mode;
    logic [pft_pkg::VAL_W-1:0]       violation;
    logic signed [pft_pkg::VAL_W-1:0] objective;

    modport source (output valid, mode, violation, objective, input ready);
    modport sink   (input valid, mode, violation, objective, output ready);
endinterface

interface pft_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [pft_pkg::OUT_CNT_W-1:0]  entry_count;
    logic [pft_pkg::OUT_CNT_W-1:0]  removed_count;
    logic                           full_drop;

    modport source (output valid, accepted, entry_count, removed_count, full_drop,
                    input ready);
    modport sink   (input valid, accepted, entry_count, removed_count, full_drop,
                    output ready);
endinterface

interface pft_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pft_pkg::CFG_IDX_W-1:0]  index;
    logic [pft_pkg::MARGIN_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/pareto_filter_table.sv */
// Pareto filter table top level: sequencer, table memory and result register.
// One transaction is handled at a time. Check, add and extract read each of the N stored
// entries once through the single read port of the table memory, and add and extract
// compact the table in place behind the read pointer. The input is ready again once the
// result is loaded into the output register. A finished result sits in an output
// register, and the next transaction is accepted while it waits; a second result stalls
// the sequencer until the first is taken. Configuration writes are taken at any time and
// should be made only while no transaction is in flight.
module pareto_filter_table (
    input  logic i_clk,
    input  logic i_rst_n,
    pft_in_if.sink    i_in,
    pft_cfg_if.sink   i_cfg,
    pft_out_if.source o_res
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_APPEND = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                      r_state, n_state;
    logic [pft_pkg::MARGIN_W-1:0]    r_beta, r_gamma;
    logic [pft_pkg::MODE_W-1:0]      r_mode, n_mode;
    logic [pft_pkg::VAL_W-1:0]       r_t, n_t, r_f, n_f, r_gt, n_gt;
    logic [pft_pkg::CNT_W-1:0]       r_count, n_count;
    logic [pft_pkg::CNT_W-1:0]       r_n, n_n;
    logic [pft_pkg::CNT_W-1:0]       r_rd, n_rd;
    logic [pft_pkg::CNT_W-1:0]       r_wr, n_wr;
    logic [pft_pkg::CNT_W-1:0]       r_removed, n_removed;
    logic                            r_fail, n_fail;
    logic                            r_drop, n_drop;
    logic                            r_v1, n_v1;
    logic                            r_ov, n_ov;
    logic                            r_acc, n_acc;
    logic [pft_pkg::OUT_CNT_W-1:0]   r_ocnt, n_ocnt, r_orem, n_orem;
    logic                            r_odrop, n_odrop;

    logic                            w_in_acc;
    logic                            w_re, w_we;
    logic [pft_pkg::ADDR_W-1:0]      w_waddr;
    pft_pkg::t_entry                 w_wdata, w_rdata;
    logic [pft_pkg::VAL_W+pft_pkg::MARGIN_W-1:0] w_gprod;
    pft_pkg::t_cmp_ctl               w_ctl;
    pft_pkg::t_cmp_res               w_res;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid         = r_ov;
    assign o_res.accepted      = r_acc;
    assign o_res.entry_count   = r_ocnt;
    assign o_res.removed_count = r_orem;
    assign o_res.full_drop     = r_odrop;

    assign w_gprod = (pft_pkg::VAL_W + pft_pkg::MARGIN_W)'(r_gamma)
                   * (pft_pkg::VAL_W + pft_pkg::MARGIN_W)'(i_in.violation);

    assign w_ctl.mode = r_mode;
    assign w_ctl.t    = r_t;
    assign w_ctl.f    = r_f;
    assign w_ctl.gt   = r_gt;
    assign w_ctl.beta = r_beta;

    pft_ram #(
        .WIDTH (pft_pkg::ENTRY_W),
        .DEPTH (pft_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd[pft_pkg::ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    pft_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_entry (w_rdata),
        .i_ctl   (w_ctl),
        .o_res   (w_res)
    );

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_t       = r_t;
        n_f       = r_f;
        n_gt      = r_gt;
        n_count   = r_count;
        n_n       = r_n;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_removed = r_removed;
        n_fail    = r_fail;
        n_drop    = r_drop;
        n_v1      = 1'b0;
        n_ov      = r_ov && !o_res.ready;
        n_acc     = r_acc;
        n_ocnt    = r_ocnt;
        n_orem    = r_orem;
        n_odrop   = r_odrop;
        w_re      = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_wr[pft_pkg::ADDR_W-1:0];
        w_wdata   = w_res.entry;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_mode    = i_in.mode;
                    n_t       = i_in.violation;
                    n_f       = i_in.objective;
                    n_gt      = w_gprod[pft_pkg::VAL_W+pft_pkg::MARGIN_W-1:pft_pkg::MARGIN_W];
                    n_n       = r_count;
                    n_rd      = '0;
                    n_wr      = '0;
                    n_removed = '0;
                    n_fail    = 1'b0;
                    n_drop    = 1'b0;
                    n_state   = (i_in.mode == pft_pkg::MODE_INIT) ? ST_APPEND : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd < r_n) begin
                    w_re = 1'b1;
                    n_rd = r_rd + 1'b1;
                    n_v1 = 1'b1;
                end
                if (w_res.valid) begin
                    if (r_mode == pft_pkg::MODE_CHECK) begin
                        if (!w_res.pass) begin
                            n_fail = 1'b1;
                        end
                    end else if (!w_res.kill) begin
                        w_we = 1'b1;
                        n_wr = r_wr + 1'b1;
                    end
                end
                if ((r_rd == r_n) && !r_v1 && !w_res.valid) begin
                    if (r_mode == pft_pkg::MODE_CHECK) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_removed = r_n - r_wr;
                        n_count   = r_wr;
                        n_state   = (r_mode == pft_pkg::MODE_ADD) ? ST_APPEND : ST_FINISH;
                    end
                end
            end
            ST_APPEND: begin
                w_wdata.viol = r_t;
                w_wdata.obj  = r_f;
                if (r_wr < pft_pkg::CNT_W'(pft_pkg::TABLE_DEPTH)) begin
                    w_we    = 1'b1;
                    n_count = r_wr + 1'b1;
                end else begin
                    n_drop  = 1'b1;
                    n_count = r_wr;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_acc   = (r_mode == pft_pkg::MODE_CHECK) && !r_fail;
                    n_ocnt  = pft_pkg::OUT_CNT_W'(r_count);
                    n_orem  = pft_pkg::OUT_CNT_W'(r_removed);
                    n_odrop = r_drop;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_v1    <= 1'b0;
            r_ov    <= 1'b0;
            r_beta  <= pft_pkg::BETA_RESET;
            r_gamma <= pft_pkg::GAMMA_RESET;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_v1    <= n_v1;
            r_ov    <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    pft_pkg::CFG_BETA:  r_beta  <= i_cfg.data;
                    pft_pkg::CFG_GAMMA: r_gamma <= i_cfg.data;
                    default: ;
                endcase
            end
        end
        r_mode    <= n_mode;
        r_t       <= n_t;
        r_f       <= n_f;
        r_gt      <= n_gt;
        r_n       <= n_n;
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_removed <= n_removed;
        r_fail    <= n_fail;
        r_drop    <= n_drop;
        r_acc     <= n_acc;
        r_ocnt    <= n_ocnt;
        r_orem    <= n_orem;
        r_odrop   <= n_odrop;
    end

endmodule

/* rtl/pft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module pft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pft_cmp.sv */
// Entry compare stage: margin product, acceptance and removal tests per entry.
module pft_cmp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pft_pkg::t_entry   i_entry,
    input  pft_pkg::t_cmp_ctl i_ctl,
    output pft_pkg::t_cmp_res o_res
);

    logic                          r_valid;
    pft_pkg::t_entry               r_entry;
    logic [pft_pkg::VAL_W-1:0]     r_bt;
    logic [pft_pkg::VAL_W+pft_pkg::MARGIN_W-1:0] w_prod;
    logic signed [pft_pkg::VAL_W+1:0] w_lhs;
    logic signed [pft_pkg::VAL_W+1:0] w_rhs;
    logic                          w_dom;
    logic                          w_eq;

    assign w_prod = (pft_pkg::VAL_W + pft_pkg::MARGIN_W)'(i_ctl.beta)
                  * (pft_pkg::VAL_W + pft_pkg::MARGIN_W)'(i_entry.viol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_entry <= i_entry;
        r_bt    <= w_prod[pft_pkg::VAL_W+pft_pkg::MARGIN_W-1:pft_pkg::MARGIN_W];
    end

    always_comb begin
        w_lhs = $signed({{2{i_ctl.f[pft_pkg::VAL_W-1]}}, i_ctl.f})
              + $signed({2'b00, i_ctl.gt});
        w_rhs = $signed({{2{r_entry.obj[pft_pkg::VAL_W-1]}}, r_entry.obj});
        w_dom = (i_ctl.t <= r_entry.viol) && ($signed(i_ctl.f) <= $signed(r_entry.obj));
        w_eq  = (i_ctl.t == r_entry.viol) && (i_ctl.f == r_entry.obj);
    end

    always_comb begin
        o_res.valid = r_valid;
        o_res.entry = r_entry;
        o_res.pass  = (i_ctl.t <= r_bt) || (w_lhs <= w_rhs);
        case (i_ctl.mode)
            pft_pkg::MODE_ADD:     o_res.kill = w_dom;
            pft_pkg::MODE_EXTRACT: o_res.kill = w_eq;
            default:               o_res.kill = 1'b0;
        endcase
    end

endmodule

/* rtl/pft_checker.sv */
// Port-level assertions for the Pareto filter table, bound to the top level.
`include "pareto_filter_table_defines.svh"

module pft_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_accepted,
    input logic [pft_pkg::OUT_CNT_W-1:0] i_entry_count,
    input logic [pft_pkg::OUT_CNT_W-1:0] i_removed_count,
    input logic                          i_full_drop
);

    `PFT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_entry_count) && $stable(i_removed_count) && $stable(i_accepted) && $stable(i_full_drop))
    `PFT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `PFT_ASSERT_IMP(a_accept_only_check, i_clk, i_rst_n, i_out_valid && i_accepted, (i_removed_count == '0) && !i_full_drop)
    `PFT_ASSERT_IMP(a_drop_when_full, i_clk, i_rst_n, i_out_valid && i_full_drop, (i_entry_count == pft_pkg::FULL_CNT) && !i_accepted)

endmodule

bind pareto_filter_table pft_checker u_pft_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_accepted      (o_res.accepted),
    .i_entry_count   (o_res.entry_count),
    .i_removed_count (o_res.removed_count),
    .i_full_drop     (o_res.full_drop)
);

/* bench/tb_pareto_filter_table.sv */
// Testbench for pareto_filter_table: random and directed operations against a filter model.
module tb_pareto_filter_table;
    import pft_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;
    localparam int PHASE_ITEMS   = 330;
    localparam int HOLD_AFTER    = 600;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [MODE_W-1:0] MODE_LIST [4] = '{MODE_CHECK, MODE_ADD, MODE_EXTRACT,
                                                    MODE_INIT};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [VAL_W-1:0]  viol;
        logic [VAL_W-1:0]  obj;
    } filter_op_t;

    typedef struct packed {
        logic                 accepted;
        logic [OUT_CNT_W-1:0] entry_count;
        logic [OUT_CNT_W-1:0] removed_count;
        logic                 full_drop;
    } filter_res_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pft_in_if  in_ch ();
    pft_cfg_if cfg_ch ();
    pft_out_if res_ch ();

    pareto_filter_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // filter model state
    logic [VAL_W-1:0]    table_viol [TABLE_DEPTH];
    logic [VAL_W-1:0]    table_obj  [TABLE_DEPTH];
    int                  table_count = 0;
    logic [MARGIN_W-1:0] beta_now    = BETA_RESET;
    logic [MARGIN_W-1:0] gamma_now   = GAMMA_RESET;

    filter_res_t expected_results [$];
    filter_op_t  pending_ops [$];
    filter_op_t  recent_pairs [$];

    logic [MARGIN_W-1:0] gen_beta  = BETA_RESET;
    logic [MARGIN_W-1:0] gen_gamma = GAMMA_RESET;

    int  ops_pushed   = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  cycles       = 0;
    int  settings_run = 0;
    int  n_check_ok   = 0;
    int  n_check_bad  = 0;
    int  n_removed    = 0;
    int  n_full       = 0;
    int  n_dropped    = 0;

    logic in_taken  = 1'b0;
    logic res_taken = 1'b0;
    int   in_gap    = 0;
    int   out_gap   = 0;
    int   long_hold = 0;
    bit   in_quiet  = 1'b0;
    bit   out_quiet = 1'b0;
    bit   hold_done = 1'b0;

    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic filter_res_t apply_filter_op(filter_op_t op);
        filter_res_t r;
        longint      lhs;
        longint      bt;
        int          wr;
        logic        kill;
        r = '0;
        case (op.mode)
            MODE_CHECK: begin
                lhs = longint'($signed(op.obj))
                    + longint'((64'(gamma_now) * 64'(op.viol)) >> 16);
                r.accepted = 1'b1;
                for (int k = 0; k < table_count; k++) begin
                    bt = longint'((64'(beta_now) * 64'(table_viol[k])) >> 16);
                    if (!(longint'(op.viol) <= bt || lhs <= longint'($signed(table_obj[k]))))
                        r.accepted = 1'b0;
                end
            end
            MODE_ADD, MODE_EXTRACT: begin
                wr = 0;
                for (int rd = 0; rd < table_count; rd++) begin
                    if (op.mode == MODE_ADD)
                        kill = (op.viol <= table_viol[rd]) &&
                               ($signed(op.obj) <= $signed(table_obj[rd]));
                    else
                        kill = (op.viol == table_viol[rd]) && (op.obj == table_obj[rd]);
                    if (!kill) begin
                        table_viol[wr] = table_viol[rd];
                        table_obj[wr]  = table_obj[rd];
                        wr++;
                    end
                end
                r.removed_count = OUT_CNT_W'(table_count - wr);
                table_count = wr;
                if (op.mode == MODE_ADD) begin
                    if (table_count < TABLE_DEPTH) begin
                        table_viol[table_count] = op.viol;
                        table_obj[table_count]  = op.obj;
                        table_count++;
                    end else begin
                        r.full_drop = 1'b1;
                    end
                end
            end
            default: begin
                table_viol[0] = op.viol;
                table_obj[0]  = op.obj;
                table_count   = 1;
            end
        endcase
        r.entry_count = OUT_CNT_W'(table_count);
        return r;
    endfunction

    // input driver
    always @(negedge i_clk) begin
        logic       nv;
        filter_op_t cur;
        nv = in_ch.valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (in_ch.valid && in_taken)
                nv = 1'b0;
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_ops.size() > 0) begin
                    cur = pending_ops.pop_front();
                    in_ch.mode      <= cur.mode;
                    in_ch.violation <= cur.viol;
                    in_ch.objective <= cur.obj;
                    nv     = 1'b1;
                    in_gap = draw_wait(in_quiet);
                end
            end
        end
        in_ch.valid <= nv;
    end

    // result receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_taken)
                out_gap = draw_wait(out_quiet);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                long_hold = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (long_hold > 0) begin
                long_hold--;
                res_ch.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        filter_op_t  op;
        filter_res_t pred;
        filter_res_t want;
        filter_res_t got;
        in_taken  <= i_rst_n && in_ch.valid && in_ch.ready;
        res_taken <= i_rst_n && res_ch.valid && res_ch.ready;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_BETA:  beta_now  = cfg_ch.data;
                    CFG_GAMMA: gamma_now = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                op.mode = in_ch.mode;
                op.viol = in_ch.violation;
                op.obj  = in_ch.objective;
                pred = apply_filter_op(op);
                if (op.mode == MODE_CHECK) begin
                    if (pred.accepted)
                        n_check_ok++;
                    else
                        n_check_bad++;
                end
                expected_results.push_back(pred);
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                got.accepted      = res_ch.accepted;
                got.entry_count   = res_ch.entry_count;
                got.removed_count = res_ch.removed_count;
                got.full_drop     = res_ch.full_drop;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: acc=%0d cnt=%0d rem=%0d drop=%0d",
                                 got.accepted, got.entry_count, got.removed_count,
                                 got.full_drop);
                end else begin
                    want = expected_results.pop_front();
                    if (want !== got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d mismatch: exp acc=%0d cnt=%0d rem=%0d drop=%0d",
                                      " got acc=%0d cnt=%0d rem=%0d drop=%0d"},
                                     results_seen, want.accepted, want.entry_count,
                                     want.removed_count, want.full_drop, got.accepted,
                                     got.entry_count, got.removed_count, got.full_drop);
                    end
                    if (want.full_drop)
                        n_dropped++;
                    if (want.entry_count == FULL_CNT)
                        n_full++;
                    n_removed += want.removed_count;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results", cycles, results_seen,
                     ops_pushed);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_op(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] viol,
                           logic [VAL_W-1:0] obj);
        filter_op_t op;
        op.mode = mode;
        op.viol = viol;
        op.obj  = obj;
        pending_ops.push_back(op);
        ops_pushed++;
        if (mode == MODE_ADD || mode == MODE_INIT) begin
            recent_pairs.push_back(op);
            if (recent_pairs.size() > 96)
                void'(recent_pairs.pop_front());
        end
    endtask

    task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [MARGIN_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_margins(logic [MARGIN_W-1:0] beta, logic [MARGIN_W-1:0] gamma);
        gen_beta  = beta;
        gen_gamma = gamma;
        cfg_put(CFG_BETA, beta);
        cfg_put(CFG_GAMMA, gamma);
        settings_run++;
    endtask

    task automatic wait_idle();
        while (results_seen < ops_pushed)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return VAL_W'($urandom_range(0, 32'h0004_0000));
            default: return $urandom();
        endcase
    endfunction

    // check pair placed on the edge of both margin tests of a recent entry
    task automatic push_near_check();
        filter_op_t       p;
        logic [63:0]      bt;
        logic [63:0]      gt;
        logic [VAL_W-1:0] t;
        if (recent_pairs.size() == 0) begin
            push_op(MODE_CHECK, rand_val(), rand_val());
        end else begin
            p  = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
            bt = (64'(gen_beta) * 64'(p.viol)) >> 16;
            t  = bt[VAL_W-1:0] + VAL_W'($urandom_range(0, 2)) - 32'd1;
            if ($urandom_range(0, 3) == 0)
                t = p.viol + VAL_W'($urandom_range(0, 8));
            gt = (64'(gen_gamma) * 64'(t)) >> 16;
            push_op(MODE_CHECK, t, p.obj - gt[VAL_W-1:0] + VAL_W'($urandom_range(0, 2)) - 32'd1);
        end
    endtask

    task automatic push_recent_extract();
        filter_op_t p;
        if (recent_pairs.size() == 0 || $urandom_range(0, 4) == 0) begin
            push_op(MODE_EXTRACT, rand_val(), rand_val());
        end else begin
            p = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
            push_op(MODE_EXTRACT, p.viol, p.obj);
        end
    endtask

    task automatic build_random(int n_items);
        int               start;
        int               run;
        logic [VAL_W-1:0] t;
        logic [VAL_W-1:0] f;
        filter_op_t       p;
        start = ops_pushed;
        while (ops_pushed - start < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    // init, then a run of adds with rising violation and mostly falling objective
                    run = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 72)
                                                      : $urandom_range(2, 20);
                    t = VAL_W'($urandom_range(0, 32'h0010_0000));
                    f = rand_val();
                    push_op(MODE_INIT, t, f);
                    repeat (run) begin
                        t = t + VAL_W'($urandom_range(1, 32'h0001_0000));
                        f = ($urandom_range(0, 3) == 0)
                            ? $urandom() : f - VAL_W'($urandom_range(0, 32'h0002_0000));
                        push_op(MODE_ADD, t, f);
                        if ($urandom_range(0, 2) == 0)
                            push_near_check();
                        if ($urandom_range(0, 7) == 0)
                            push_recent_extract();
                    end
                    repeat ($urandom_range(1, 4)) push_near_check();
                end
                6: begin
                    if (recent_pairs.size() == 0) begin
                        push_op(MODE_ADD, rand_val(), rand_val());
                    end else begin
                        p = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
                        push_op(MODE_ADD, p.viol - VAL_W'($urandom_range(0, 32'h0003_0000)),
                                p.obj - VAL_W'($urandom_range(0, 32'h0003_0000)));
                    end
                end
                7: push_recent_extract();
                8: push_op(MODE_CHECK, rand_val(), rand_val());
                default: push_op(MODE_LIST[$urandom_range(0, 3)], $urandom(), $urandom());
            endcase
        end
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_CHECK;
        in_ch.violation  = '0;
        in_ch.objective  = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_BETA;
        cfg_ch.data      = '0;
        res_ch.ready     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_margins(BETA_RESET, GAMMA_RESET);
        push_op(MODE_CHECK,   32'h0000_0000, 32'h0000_0000);
        push_op(MODE_CHECK,   32'hFFFF_FFFF, 32'h8000_0000);
        push_op(MODE_EXTRACT, 32'h0000_0000, 32'h0000_0000);
        push_op(MODE_ADD,     32'h0001_0000, 32'h0002_0000);
        push_op(MODE_ADD,     32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_op(MODE_CHECK,   32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_op(MODE_ADD,     32'h0000_0000, 32'h8000_0000);
        push_op(MODE_CHECK,   32'h0000_0000, 32'h8000_0000);
        push_op(MODE_CHECK,   32'h0000_0001, 32'h7FFF_FFFF);
        push_op(MODE_INIT,    32'h0000_0005, 32'hFFFF_FFFB);
        push_op(MODE_ADD,     32'h0000_0005, 32'hFFFF_FFFB);
        push_op(MODE_ADD,     32'h0000_0006, 32'hFFFF_FFFA);
        push_op(MODE_ADD,     32'h0000_0004, 32'h0000_0007);
        push_op(MODE_EXTRACT, 32'h0000_0006, 32'hFFFF_FFFA);
        push_op(MODE_EXTRACT, 32'h0000_0123, 32'h0000_0456);
        push_op(MODE_CHECK,   32'h0000_0003, 32'h0000_0000);
        push_op(MODE_INIT,    32'hFFFF_FFFF, 32'h8000_0000);
        push_op(MODE_CHECK,   32'h0000_0000, 32'h7FFF_FFFF);
        push_op(MODE_ADD,     32'h7FFF_FFFF, 32'h8000_0000);
        build_random(PHASE_ITEMS / 2);

        wait_idle();
        write_margins(16'hFFFF, 16'hFFFF);
        build_random(PHASE_ITEMS);
        wait_idle();
        write_margins(16'h0000, 16'h0000);
        build_random(PHASE_ITEMS);
        wait_idle();
        write_margins(MARGIN_W'($urandom()), MARGIN_W'($urandom()));
        build_random(PHASE_ITEMS);
        wait_idle();
        write_margins(16'h0000, 16'hFFFF);
        build_random(PHASE_ITEMS);
        wait_idle();
        write_margins(16'hFFFF, 16'h0000);
        build_random(PHASE_ITEMS);
        wait_idle();
        write_margins(BETA_RESET, GAMMA_RESET);
        build_random(PHASE_ITEMS);
        wait_idle();

        $display("covered %0d transactions over %0d margin settings, %0d cycles, %0d/%0d checks ok",
                 results_seen, settings_run, cycles, n_check_ok, n_check_ok + n_check_bad);
        $display("table full in %0d results, %0d adds dropped, %0d entries removed",
                 n_full, n_dropped, n_removed);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule
